// ----- hdl/eebz_pkg.sv -----
package eebz_pkg;

    localparam int DEF_OPERAND_WIDTH = 64;
    localparam int DEF_MAX_STEPS     = 96;
    localparam int STEPS_W           = 7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_START,
        S_DIV_WAIT,
        S_BS_CHECK,
        S_BS_LOAD,
        S_MUL,
        S_MOD_START,
        S_MOD_WAIT,
        S_MM,
        S_BS_UPD,
        S_FIN
    } t_state;

endpackage

// ----- hdl/eebz_ram.sv -----
module eebz_ram #(
    parameter int WIDTH = 63,
    parameter int DEPTH = 96
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/eebz_div.sv -----
module eebz_div #(
    parameter int N = 63
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [N-1:0] i_dividend,
    input  logic [N-1:0] i_divisor,
    output logic         o_done,
    output logic [N-1:0] o_quo,
    output logic [N-1:0] o_rem
);
    localparam int CW = $clog2(N + 1);

    logic [N:0]    r_rem, n_rem;
    logic [N-1:0]  r_quo, n_quo;
    logic [N-1:0]  r_div;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [N:0]    w_sh;

    // One restoring step per cycle: shift in the next dividend bit, try a subtract.
    always_comb begin
        w_sh   = {r_rem[N-1:0], r_quo[N-1]};
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_dividend;
            n_cnt  = CW'(N);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_div}) begin
                n_rem = w_sh - {1'b0, r_div};
                n_quo = {r_quo[N-2:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_quo = {r_quo[N-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_start) begin
            r_div <= i_divisor;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem[N-1:0];

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("divider busy with zero count");
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < {1'b0, r_div}))
        else $error("divider remainder not below divisor");
endmodule

// ----- hdl/extended_euclid_bezout_core.sv -----
// Extended Euclid core: gcd, step count and Bezout coefficients of one operand pair.
// Each division row runs on the shared restoring divider. Back-substitution per row uses a
// shift-and-add multiply, or in reduce mode a remainder division plus a double-and-add
// modular multiply.
// One item at a time: input stall stays high from acceptance until the result is registered.
// Reset (synchronous, active low) clears the sequencer, the output valid and the mode register.
module extended_euclid_bezout_core
    #(
    parameter int OPERAND_WIDTH = eebz_pkg::DEF_OPERAND_WIDTH,
    parameter int MAX_STEPS     = eebz_pkg::DEF_MAX_STEPS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [OPERAND_WIDTH-2:0]        i_first_value,
    input  logic [OPERAND_WIDTH-2:0]        i_second_value,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [OPERAND_WIDTH-2:0]        o_gcd_value,
    output logic signed [OPERAND_WIDTH-1:0] o_coeff_first,
    output logic signed [OPERAND_WIDTH-1:0] o_coeff_second,
    output logic [eebz_pkg::STEPS_W-1:0]    o_division_steps
);
    import eebz_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int N  = W - 1;
    localparam int CW = $clog2(MAX_STEPS + 1);
    localparam int AW = $clog2(MAX_STEPS);
    localparam int BW = $clog2(W);

    // Sequencer and working registers.
    t_state        r_state, n_state;
    logic          r_reduce_cfg;
    logic          r_reduce, n_reduce;
    logic [N-1:0]  r_a, n_a;
    logic [N-1:0]  r_x, n_x;
    logic [N-1:0]  r_y, n_y;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_bi, n_bi;
    logic [W-1:0]  r_cb, n_cb;
    logic [W-1:0]  r_ck, n_ck;
    logic [W-1:0]  r_acc, n_acc;
    logic [W-1:0]  r_mq, n_mq;
    logic [W-1:0]  r_mc, n_mc;
    logic [BW-1:0] r_bit, n_bit;
    logic          r_phase, n_phase;

    // Output register.
    logic          r_ovalid, n_ovalid;
    logic [N-1:0]  r_ogcd, n_ogcd;
    logic [W-1:0]  r_ocb, n_ocb;
    logic [W-1:0]  r_ock, n_ock;
    logic [CW-1:0] r_osteps, n_osteps;

    // Shared divider and quotient memory.
    logic          w_div_start;
    logic [N-1:0]  w_div_dnd, w_div_dvs;
    logic          w_div_done;
    logic [N-1:0]  w_div_quo, w_div_rem;
    logic          w_ram_we;
    logic [N-1:0]  w_ram_rdata;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [CW-1:0] w_bi_m1;

    logic [W-1:0]  w_sum, w_base, w_diff;
    logic          w_accept;

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_bi_m1  = r_bi - 1'b1;
    assign w_waddr  = r_n[AW-1:0];
    assign w_raddr  = w_bi_m1[AW-1:0];

    eebz_div #(.N(N)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_dividend(w_div_dnd),
        .i_divisor (w_div_dvs),
        .o_done    (w_div_done),
        .o_quo     (w_div_quo),
        .o_rem     (w_div_rem)
    );

    eebz_ram #(.WIDTH(N), .DEPTH(MAX_STEPS)) u_qram (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(w_waddr),
        .i_wdata(w_div_quo),
        .i_raddr(w_raddr),
        .o_rdata(w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ovalid     <= 1'b0;
            r_reduce_cfg <= 1'b0;
            r_n          <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_n      <= n_n;
            if (i_cfg_we) begin
                r_reduce_cfg <= i_cfg_wdata;
            end
        end
        r_reduce <= n_reduce;
        r_a      <= n_a;
        r_x      <= n_x;
        r_y      <= n_y;
        r_bi     <= n_bi;
        r_cb     <= n_cb;
        r_ck     <= n_ck;
        r_acc    <= n_acc;
        r_mq     <= n_mq;
        r_mc     <= n_mc;
        r_bit    <= n_bit;
        r_phase  <= n_phase;
        r_ogcd   <= n_ogcd;
        r_ocb    <= n_ocb;
        r_ock    <= n_ock;
        r_osteps <= n_osteps;
    end

    always_comb begin
        n_state     = r_state;
        n_reduce    = r_reduce;
        n_a         = r_a;
        n_x         = r_x;
        n_y         = r_y;
        n_n         = r_n;
        n_bi        = r_bi;
        n_cb        = r_cb;
        n_ck        = r_ck;
        n_acc       = r_acc;
        n_mq        = r_mq;
        n_mc        = r_mc;
        n_bit       = r_bit;
        n_phase     = r_phase;
        n_ovalid    = r_ovalid;
        n_ogcd      = r_ogcd;
        n_ocb       = r_ocb;
        n_ock       = r_ock;
        n_osteps    = r_osteps;
        w_div_start = 1'b0;
        w_div_dnd   = r_x;
        w_div_dvs   = r_y;
        w_ram_we    = 1'b0;
        w_sum       = '0;
        w_base      = '0;
        w_diff      = '0;
        o_in_stall  = (r_state != S_IDLE);

        // The consumer takes the result; the register frees up.
        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_a      = i_first_value;
                    n_x      = i_first_value;
                    n_y      = i_second_value;
                    n_n      = '0;
                    n_reduce = r_reduce_cfg && (i_first_value != '0);
                    n_state  = S_DIV_START;
                end
            end
            // Euclid chain: one division row per pass through the shared divider.
            S_DIV_START: begin
                if (r_y == '0 || r_n == CW'(MAX_STEPS)) begin
                    n_bi    = r_n;
                    n_cb    = W'(1);
                    n_ck    = '0;
                    n_state = S_BS_CHECK;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT: begin
                if (w_div_done) begin
                    w_ram_we = 1'b1;
                    n_x      = r_y;
                    n_y      = w_div_rem;
                    n_n      = r_n + 1'b1;
                    n_state  = S_DIV_START;
                end
            end
            // Back-substitution walks the stored quotients from the last row down.
            S_BS_CHECK: begin
                if (r_bi == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_BS_LOAD;
                end
            end
            S_BS_LOAD: begin
                if (r_reduce) begin
                    n_mq    = {1'b0, w_ram_rdata};
                    n_state = S_MOD_START;
                end else begin
                    n_acc   = '0;
                    n_mq    = {1'b0, w_ram_rdata};
                    n_mc    = r_ck;
                    n_bit   = BW'(W - 1);
                    n_state = S_MUL;
                end
            end
            // Plain mode: shift-and-add product q*k, wrapping at the word width.
            S_MUL: begin
                if (r_mq[0]) begin
                    n_acc = r_acc + r_mc;
                end
                n_mq  = r_mq >> 1;
                n_mc  = r_mc << 1;
                n_bit = r_bit - 1'b1;
                if (r_bit == '0) begin
                    n_state = S_BS_UPD;
                end
            end
            // Reduce mode: q mod a on the divider, then a double-and-add modular multiply.
            S_MOD_START: begin
                w_div_start = 1'b1;
                w_div_dnd   = r_mq[N-1:0];
                w_div_dvs   = r_a;
                n_state     = S_MOD_WAIT;
            end
            S_MOD_WAIT: begin
                w_div_dnd = r_mq[N-1:0];
                w_div_dvs = r_a;
                if (w_div_done) begin
                    n_mq    = {1'b0, w_div_rem};
                    n_acc   = '0;
                    n_bit   = BW'(W - 1);
                    n_phase = 1'b0;
                    n_state = S_MM;
                end
            end
            S_MM: begin
                // Phase 0 doubles the running product, phase 1 adds q when the bit of k is set.
                if (!r_phase) begin
                    w_sum = r_acc + r_acc;
                end else begin
                    w_sum = r_ck[r_bit] ? (r_acc + r_mq) : r_acc;
                end
                n_acc   = (w_sum >= {1'b0, r_a}) ? (w_sum - {1'b0, r_a}) : w_sum;
                n_phase = !r_phase;
                if (r_phase) begin
                    n_bit = r_bit - 1'b1;
                    if (r_bit == '0) begin
                        n_state = S_BS_UPD;
                    end
                end
            end
            S_BS_UPD: begin
                if (r_reduce) begin
                    // The old b is 1 at the start or already below a.
                    w_base = (r_cb >= {1'b0, r_a}) ? (r_cb - {1'b0, r_a}) : r_cb;
                    w_diff = w_base - r_acc;
                    n_ck   = (w_base >= r_acc) ? w_diff : (w_diff + {1'b0, r_a});
                end else begin
                    n_ck = r_cb - r_acc;
                end
                n_cb    = r_ck;
                n_bi    = w_bi_m1;
                n_state = S_BS_CHECK;
            end
            S_FIN: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid = 1'b1;
                    n_ogcd   = r_x;
                    n_ocb    = r_cb;
                    n_ock    = r_ck;
                    n_osteps = r_n;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid      = r_ovalid;
    assign o_gcd_value      = r_ogcd;
    assign o_coeff_first    = r_ocb;
    assign o_coeff_second   = r_ock;
    assign o_division_steps = STEPS_W'(r_osteps);

    a_rows_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CW'(MAX_STEPS))
        else $error("division row count beyond capacity");
    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV_WAIT || r_state == S_MOD_WAIT))
        else $error("divider finished outside a wait state");
    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_FIN))
        else $error("result appeared without finishing an item");
    a_bs_within_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BS_LOAD) |-> (r_bi != '0 && r_bi <= r_n))
        else $error("back-substitution index out of range");
endmodule
